### hw/rtl/assert_macros.svh
// Assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define BPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define BPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator
package bpa_pkg;

  localparam int NUM_PAGES_DEF = 4096;
  localparam int TOP_ORDER_DEF = 10;

  localparam int MODE_W    = 2;
  localparam int ORD_W     = 4;
  localparam int PIDX_W    = 12;
  localparam int CNT_W     = 13;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 1'b1;

  // write enables of the three page stores
  typedef struct packed {
    logic info;
    logic nxt;
    logic prv;
  } store_we_t;

endpackage

### hw/rtl/bpa_page_store.sv
// Per-page storage: free flag and order, next link, previous link
module bpa_page_store #(
  parameter int NUM_PAGES = 4096,
  parameter int AW        = 12,
  parameter int LW        = 13
) (
  input  logic                     clk,
  input  bpa_pkg::store_we_t       we,
  input  logic [AW-1:0]            waddr_info,
  input  logic [bpa_pkg::ORD_W:0]  wdata_info,
  input  logic [AW-1:0]            waddr_nxt,
  input  logic [LW-1:0]            wdata_nxt,
  input  logic [AW-1:0]            waddr_prv,
  input  logic [LW-1:0]            wdata_prv,
  input  logic [AW-1:0]            raddr,
  output logic [bpa_pkg::ORD_W:0]  rdata_info,
  output logic [LW-1:0]            rdata_nxt,
  output logic [LW-1:0]            rdata_prv
);
  import bpa_pkg::*;

  logic [ORD_W:0]  info_mem [0:NUM_PAGES-1];
  logic [LW-1:0]   nxt_mem  [0:NUM_PAGES-1];
  logic [LW-1:0]   prv_mem  [0:NUM_PAGES-1];

  always_ff @(posedge clk) begin
    if (we.info) begin
      info_mem[waddr_info] <= wdata_info;
    end
    rdata_info <= info_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.nxt) begin
      nxt_mem[waddr_nxt] <= wdata_nxt;
    end
    rdata_nxt <= nxt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.prv) begin
      prv_mem[waddr_prv] <= wdata_prv;
    end
    rdata_prv <= prv_mem[raddr];
  end

endmodule

### hw/rtl/buddy_page_allocator.sv
// Buddy page allocator top level: sequencer, free list heads and page store
//
//  channel  dir  ports                                      transaction
//  in       in   start, busy, in_mode/block_order/page_index start & !busy
//  out      out  out_valid, out_status/alloc_page/free_total out_valid, 1 cycle
//  cfg      in   cfg_we, cfg_index, cfg_wdata                cfg_we
//
// Busy after the accept: mode 3 and refusals go straight to the result; allocate
//   searches past empty orders, then lists each upper half that lies in memory;
//   free checks the buddy and merges while it is free; init clears the store
//   and lists each block. Then one strobe cycle. Reset runs a store clear with
//   busy high.
// Each list step is a store read, a check and writes. The receiver cannot stall.
module buddy_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
  parameter int TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpa_pkg::MODE_W-1:0]    in_mode,
  input  logic [bpa_pkg::ORD_W-1:0]     in_block_order,
  input  logic [bpa_pkg::PIDX_W-1:0]    in_page_index,
  output logic                          out_valid,
  output logic [bpa_pkg::STAT_W-1:0]    out_status,
  output logic [bpa_pkg::PIDX_W-1:0]    out_alloc_page,
  output logic [bpa_pkg::CNT_W-1:0]     out_free_total,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_wdata
);
  import bpa_pkg::*;

  `include "assert_macros.svh"

  localparam int AW  = $clog2(NUM_PAGES);
  localparam int LW  = $clog2(NUM_PAGES + 1);
  localparam int VW0 = (LW > CNT_W) ? LW : CNT_W;
  localparam int VW  = (VW0 > TOP_ORDER + 2) ? VW0 : TOP_ORDER + 2;
  localparam int KW  = (TOP_ORDER > 0) ? $clog2(TOP_ORDER + 1) : 1;
  localparam int KRW = ORD_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_I_TEST, S_I_SRCH, S_I_ADD, S_A_SRCH, S_A_SPLIT, S_A_FIN,
    S_F_LOOP, S_F_RD, S_F_CHK, S_F_MERGE, S_F_FIN, S_U_RD, S_U_CHK, S_P_W1,
    S_P_W2, S_DONE
  } state_t;

  state_t            state_r, ret_r;
  logic [ORD_W-1:0]  ord_r;
  logic [KRW-1:0]    k_r;
  logic [VW-1:0]     base_r, tp_r, link_r, ftot_r, apage_r;
  logic [ORD_W-1:0]  pk_r;
  logic              at_tail_r, uonly_r, clr_init_r;
  logic [AW-1:0]     ra_r, ca_r;
  status_t           stat_r;
  logic [CNT_W-1:0]  tot_cfg_r, first_cfg_r;
  logic [VW-1:0]     hd_r  [0:TOP_ORDER];
  logic [VW-1:0]     tl_r  [0:TOP_ORDER];
  logic [VW-1:0]     cnt_r [0:TOP_ORDER];
  logic              out_valid_r;
  status_t           out_status_r;
  logic [PIDX_W-1:0] out_page_r;
  logic [CNT_W-1:0]  out_ftot_r;

  // page store ports
  store_we_t         st_we;
  logic [AW-1:0]     wa_info, wa_nxt, wa_prv;
  logic [ORD_W:0]    wd_info, r_info;
  logic [LW-1:0]     wd_nxt, wd_prv, r_nxt_raw, r_prv_raw;

  logic [VW-1:0]     nil, total, r_nx, r_pv, pw, pwh, po, b_split, b_buddy, pin;
  logic [VW:0]       sum_init, sum_split, sum_ftot;
  logic              r_free;
  logic [ORD_W-1:0]  r_ord;
  logic [KW-1:0]     kidx, pidx, oidx;
  logic              accept;

  assign nil     = VW'(NUM_PAGES);
  assign total   = (VW'(tot_cfg_r) > nil) ? nil : VW'(tot_cfg_r);
  assign r_free  = r_info[ORD_W];
  assign r_ord   = r_info[ORD_W-1:0];
  assign r_nx    = VW'(r_nxt_raw);
  assign r_pv    = VW'(r_prv_raw);
  assign pw      = VW'(1) << k_r;
  assign pwh     = pw >> 1;
  assign po      = VW'(1) << ord_r;
  assign kidx    = k_r[KW-1:0];
  assign pidx    = pk_r[KW-1:0];
  assign oidx    = r_ord[KW-1:0];
  assign b_split = base_r + pwh;
  assign b_buddy = base_r ^ pw;
  assign pin     = VW'(in_page_index);
  assign sum_init  = {1'b0, base_r} + {1'b0, pw};
  assign sum_split = {1'b0, base_r} + {1'b0, pwh};
  assign sum_ftot  = {1'b0, ftot_r} + {1'b0, (state_r == S_I_ADD) ? pw : po};
  assign accept  = start && !busy;

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_page = out_page_r;
  assign out_free_total = out_ftot_r;

  bpa_page_store #(
    .NUM_PAGES (NUM_PAGES),
    .AW        (AW),
    .LW        (LW)
  ) u_store (
    .clk        (clk),
    .we         (st_we),
    .waddr_info (wa_info),
    .wdata_info (wd_info),
    .waddr_nxt  (wa_nxt),
    .wdata_nxt  (wd_nxt),
    .waddr_prv  (wa_prv),
    .wdata_prv  (wd_prv),
    .raddr      (ra_r),
    .rdata_info (r_info),
    .rdata_nxt  (r_nxt_raw),
    .rdata_prv  (r_prv_raw)
  );

  // store write control
  always_comb begin
    st_we   = '0;
    wa_info = '0;
    wd_info = '0;
    wa_nxt  = '0;
    wd_nxt  = '0;
    wa_prv  = '0;
    wd_prv  = '0;
    case (state_r)
      S_CLR: begin
        st_we.info = 1'b1;
        wa_info    = ca_r;
      end
      S_U_CHK: begin
        // unlink: splice neighbors, clear the free flag, keep the order
        if (r_free && (VW'(r_ord) <= VW'(TOP_ORDER))) begin
          st_we.info = 1'b1;
          wa_info    = tp_r[AW-1:0];
          wd_info    = {1'b0, r_ord};
          if (r_pv < nil) begin
            st_we.nxt = 1'b1;
            wa_nxt    = r_pv[AW-1:0];
            wd_nxt    = r_nxt_raw;
          end
          if (r_nx < nil) begin
            st_we.prv = 1'b1;
            wa_prv    = r_nx[AW-1:0];
            wd_prv    = r_prv_raw;
          end
        end
      end
      S_P_W1: begin
        st_we.info = 1'b1;
        wa_info    = tp_r[AW-1:0];
        wd_info    = {1'b1, pk_r};
        st_we.nxt  = 1'b1;
        st_we.prv  = 1'b1;
        wa_nxt     = tp_r[AW-1:0];
        wa_prv     = tp_r[AW-1:0];
        if (at_tail_r) begin
          wd_nxt = LW'(nil);
          wd_prv = LW'(tl_r[pidx]);
        end else begin
          wd_nxt = LW'(hd_r[pidx]);
          wd_prv = LW'(nil);
        end
      end
      S_P_W2: begin
        // back link from the old end of the list
        if (link_r < nil) begin
          if (at_tail_r) begin
            st_we.nxt = 1'b1;
            wa_nxt    = link_r[AW-1:0];
            wd_nxt    = LW'(tp_r);
          end else begin
            st_we.prv = 1'b1;
            wa_prv    = link_r[AW-1:0];
            wd_prv    = LW'(tp_r);
          end
        end
      end
      S_A_FIN: begin
        st_we.info = 1'b1;
        wa_info    = base_r[AW-1:0];
        wd_info    = {1'b0, ord_r};
      end
      default: begin
      end
    endcase
  end

  // sequencer, list heads and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_IDLE;
      clr_init_r  <= 1'b0;
      ca_r        <= '0;
      ftot_r      <= '0;
      tot_cfg_r   <= CNT_W'(4096);
      first_cfg_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
        hd_r[i]  <= VW'(NUM_PAGES);
        tl_r[i]  <= VW'(NUM_PAGES);
        cnt_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL: tot_cfg_r   <= cfg_wdata;
          CFG_FIRST: first_cfg_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            ord_r   <= in_block_order;
            stat_r  <= ST_OK;
            apage_r <= '0;
            case (mode_t'(in_mode))
              MODE_INIT: begin
                ca_r       <= '0;
                clr_init_r <= 1'b1;
                ftot_r     <= '0;
                for (int i = 0; i <= TOP_ORDER; i++) begin
                  hd_r[i]  <= nil;
                  tl_r[i]  <= nil;
                  cnt_r[i] <= '0;
                end
                state_r <= S_CLR;
              end
              MODE_ALLOC: begin
                if (VW'(in_block_order) > VW'(TOP_ORDER)) begin
                  stat_r  <= ST_ORDER;
                  state_r <= S_DONE;
                end else begin
                  k_r     <= KRW'(in_block_order);
                  state_r <= S_A_SRCH;
                end
              end
              MODE_FREE: begin
                if (VW'(in_block_order) > VW'(TOP_ORDER)) begin
                  stat_r  <= ST_ORDER;
                  state_r <= S_DONE;
                end else if (pin >= total) begin
                  stat_r  <= ST_RANGE;
                  state_r <= S_DONE;
                end else begin
                  base_r  <= pin;
                  k_r     <= KRW'(in_block_order);
                  state_r <= S_F_LOOP;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          ca_r <= ca_r + 1'b1;
          if (ca_r == AW'(NUM_PAGES - 1)) begin
            clr_init_r <= 1'b0;
            base_r     <= VW'(first_cfg_r);
            state_r    <= clr_init_r ? S_I_TEST : S_IDLE;
          end
        end
        S_I_TEST: begin
          if (base_r < total) begin
            k_r     <= KRW'(TOP_ORDER);
            state_r <= S_I_SRCH;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_I_SRCH: begin
          // largest aligned block that still fits
          if (k_r != '0 && !(((base_r & (pw - 1'b1)) == '0) &&
                             (sum_init <= {1'b0, total}))) begin
            k_r <= k_r - 1'b1;
          end else begin
            tp_r      <= base_r;
            pk_r      <= k_r[ORD_W-1:0];
            at_tail_r <= 1'b1;
            uonly_r   <= 1'b0;
            ra_r      <= base_r[AW-1:0];
            ret_r     <= S_I_ADD;
            state_r   <= S_U_RD;
          end
        end
        S_I_ADD: begin
          ftot_r  <= (sum_ftot > {1'b0, total}) ? total : sum_ftot[VW-1:0];
          base_r  <= sum_init[VW-1:0];
          state_r <= S_I_TEST;
        end
        S_A_SRCH: begin
          if (VW'(k_r) > VW'(TOP_ORDER)) begin
            stat_r  <= ST_EMPTY;
            state_r <= S_DONE;
          end else if (hd_r[kidx] == nil) begin
            k_r <= k_r + 1'b1;
          end else begin
            base_r  <= hd_r[kidx];
            tp_r    <= hd_r[kidx];
            ra_r    <= hd_r[kidx][AW-1:0];
            uonly_r <= 1'b1;
            ret_r   <= S_A_SPLIT;
            state_r <= S_U_RD;
          end
        end
        S_A_SPLIT: begin
          if (k_r > KRW'(ord_r)) begin
            k_r <= k_r - 1'b1;
            // upper halves past memory are dropped
            if (sum_split < {1'b0, total}) begin
              tp_r      <= b_split;
              pk_r      <= ORD_W'(k_r - 1'b1);
              at_tail_r <= 1'b0;
              uonly_r   <= 1'b0;
              ra_r      <= b_split[AW-1:0];
              ret_r     <= S_A_SPLIT;
              state_r   <= S_U_RD;
            end
          end else begin
            state_r <= S_A_FIN;
          end
        end
        S_A_FIN: begin
          ftot_r  <= (ftot_r > po) ? ftot_r - po : '0;
          apage_r <= base_r;
          state_r <= S_DONE;
        end
        S_F_LOOP: begin
          if ((VW'(k_r) < VW'(TOP_ORDER)) && (b_buddy < total)) begin
            tp_r    <= b_buddy;
            ra_r    <= b_buddy[AW-1:0];
            state_r <= S_F_RD;
          end else begin
            tp_r      <= base_r;
            pk_r      <= k_r[ORD_W-1:0];
            at_tail_r <= 1'b0;
            uonly_r   <= 1'b0;
            ra_r      <= base_r[AW-1:0];
            ret_r     <= S_F_FIN;
            state_r   <= S_U_RD;
          end
        end
        S_F_RD: state_r <= S_F_CHK;
        S_F_CHK: begin
          if (r_free && (r_ord == k_r[ORD_W-1:0])) begin
            uonly_r <= 1'b1;
            ret_r   <= S_F_MERGE;
            state_r <= S_U_RD;
          end else begin
            tp_r      <= base_r;
            pk_r      <= k_r[ORD_W-1:0];
            at_tail_r <= 1'b0;
            uonly_r   <= 1'b0;
            ra_r      <= base_r[AW-1:0];
            ret_r     <= S_F_FIN;
            state_r   <= S_U_RD;
          end
        end
        S_F_MERGE: begin
          base_r  <= base_r & tp_r;
          k_r     <= k_r + 1'b1;
          state_r <= S_F_LOOP;
        end
        S_F_FIN: begin
          ftot_r  <= (sum_ftot > {1'b0, total}) ? total : sum_ftot[VW-1:0];
          state_r <= S_DONE;
        end
        S_U_RD: state_r <= S_U_CHK;
        S_U_CHK: begin
          if (r_free && (VW'(r_ord) <= VW'(TOP_ORDER))) begin
            if (r_pv >= nil) hd_r[oidx] <= r_nx;
            if (r_nx >= nil) tl_r[oidx] <= r_pv;
            if (cnt_r[oidx] != '0) cnt_r[oidx] <= cnt_r[oidx] - 1'b1;
          end
          state_r <= uonly_r ? ret_r : S_P_W1;
        end
        S_P_W1: begin
          link_r       <= at_tail_r ? tl_r[pidx] : hd_r[pidx];
          cnt_r[pidx]  <= cnt_r[pidx] + 1'b1;
          if (at_tail_r) begin
            if (tl_r[pidx] >= nil) hd_r[pidx] <= tp_r;
            tl_r[pidx] <= tp_r;
          end else begin
            if (hd_r[pidx] >= nil) tl_r[pidx] <= tp_r;
            hd_r[pidx] <= tp_r;
          end
          state_r <= S_P_W2;
        end
        S_P_W2: state_r <= ret_r;
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_status_r <= stat_r;
          out_page_r   <= PIDX_W'(apage_r);
          out_ftot_r   <= CNT_W'(ftot_r);
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BPA_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `BPA_ASSERT(a_accept_busy, accept |=> busy, "transaction accepted but not busy")
  `BPA_ASSERT(a_result_idle, out_valid |-> !busy, "result shown while still busy")
  `BPA_ASSERT(a_page_zero, out_valid && (out_status != ST_OK) |-> (out_alloc_page == '0), "refused transaction returns a page")

endmodule
